@@ rtl/assert_macros.svh @@
// Assertion macros shared by the chunked body decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define HCBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define HCBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define HCBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define HCBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/hcbd_pkg.sv @@
// Types, constants and character helpers for the chunked body decoder.
package hcbd_pkg;

	localparam int SIZE_BITS  = 32;
	localparam int LINE_LIMIT = 4096;
	localparam int LINE_W     = $clog2(LINE_LIMIT);
	localparam int LEFT_W     = SIZE_BITS + 1;

	localparam logic [2:0] PH_LINE = 3'd0;
	localparam logic [2:0] PH_REST = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_DONE = 3'd3;
	localparam logic [2:0] PH_ERR  = 3'd4;

	localparam logic [2:0] EV_DATA    = 3'd0;
	localparam logic [2:0] EV_FINAL   = 3'd1;
	localparam logic [2:0] EV_BADLINE = 3'd2;
	localparam logic [2:0] EV_SHORT   = 3'd3;
	localparam logic [2:0] EV_NOLF    = 3'd4;
	localparam logic [2:0] EV_NOTERM  = 3'd5;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_UP = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] event_res;
		logic       last_of_chunk;
	} out_word_t;

	// Bit 4 flags a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_val(logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			r = {1'b1, 4'(b - CH_ZERO)};
		end else if (b >= CH_LA && b <= CH_LF_UP) begin
			r = {1'b1, 4'(b - CH_LA + 8'd10)};
		end else if (b >= CH_UA && b <= CH_UF) begin
			r = {1'b1, 4'(b - CH_UA + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
			(b == CH_VT) || (b == CH_FF);
	endfunction

endpackage

@@ rtl/hcbd_core.sv @@
// Framing state and per-word step logic of the chunked body decoder.
module hcbd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  hcbd_pkg::in_word_t  word,
	output logic              res_valid,
	output hcbd_pkg::out_word_t res
);
	import hcbd_pkg::*;

	logic [2:0]           phase_q, phase_d;
	logic [SIZE_BITS-1:0] chunk_q, chunk_d;
	logic [LEFT_W-1:0]    left_q, left_d;
	logic [LINE_W-1:0]    line_q, line_d;
	logic                 digit_q, digit_d;
	logic                 fwz_q, fwz_d;
	logic [4:0]           hv;
	logic [7:0]           b;

	assign b  = word.in_byte;
	assign hv = hex_val(b);

	always_comb begin
		phase_d   = phase_q;
		chunk_d   = chunk_q;
		left_d    = left_q;
		line_d    = line_q;
		digit_d   = digit_q;
		fwz_d     = fwz_q;
		res_valid = 1'b0;
		res       = '0;
		if (phase_q == PH_DATA) begin
			if (word.kind) begin
				res_valid     = 1'b1;
				res.event_res = EV_SHORT;
				phase_d       = PH_ERR;
			end else if (left_q > LEFT_W'(2)) begin
				res_valid         = 1'b1;
				res.event_res     = EV_DATA;
				res.out_byte      = b;
				res.last_of_chunk = (left_q == LEFT_W'(3));
				left_d            = left_q - LEFT_W'(1);
			end else if (left_q == LEFT_W'(2)) begin
				left_d = LEFT_W'(1);
			end else begin
				left_d = '0;
				if (b != CH_LF) begin
					res_valid     = 1'b1;
					res.event_res = EV_NOLF;
					phase_d       = PH_ERR;
				end else begin
					phase_d = PH_LINE;
					chunk_d = '0;
					line_d  = '0;
					digit_d = 1'b0;
					fwz_d   = 1'b0;
				end
			end
		end else if (phase_q == PH_LINE || phase_q == PH_REST) begin
			if (word.kind || b == CH_LF) begin
				if (chunk_q == '0) begin
					res_valid     = 1'b1;
					res.event_res = fwz_q ? EV_FINAL : EV_NOTERM;
					phase_d       = fwz_q ? PH_DONE : PH_ERR;
				end else if (word.kind) begin
					res_valid     = 1'b1;
					res.event_res = EV_SHORT;
					phase_d       = PH_ERR;
				end else begin
					left_d  = {1'b0, chunk_q} + LEFT_W'(2);
					phase_d = PH_DATA;
				end
			end else if (line_q >= LINE_W'(LINE_LIMIT - 2)) begin
				res_valid     = 1'b1;
				res.event_res = EV_BADLINE;
				phase_d       = PH_ERR;
			end else begin
				if (line_q == '0 && b == CH_ZERO) begin
					fwz_d = 1'b1;
				end
				line_d = line_q + LINE_W'(1);
				if (phase_q == PH_LINE) begin
					if (hv[4]) begin
						if (chunk_q[SIZE_BITS-1 -: 4] != 4'd0) begin
							res_valid     = 1'b1;
							res.event_res = EV_BADLINE;
							phase_d       = PH_ERR;
						end else begin
							chunk_d = {chunk_q[SIZE_BITS-5:0], hv[3:0]};
							digit_d = 1'b1;
						end
					end else if (digit_q || !is_blank(b)) begin
						phase_d = PH_REST;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE;
			chunk_q <= '0;
			left_q  <= '0;
			line_q  <= '0;
			digit_q <= 1'b0;
			fwz_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			chunk_q <= chunk_d;
			left_q  <= left_d;
			line_q  <= line_d;
			digit_q <= digit_d;
			fwz_q   <= fwz_d;
		end
	end

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// Top level of the chunked transfer body decoder with input and result registers.
// Strips chunked transfer framing from a response body, one received word (a byte or an
// end-of-stream mark) per clock while input stall is low. Each word is captured in an input
// register, decoded combinationally against the framing state, and any result goes to an
// output register, so a word is taken every cycle unless input stall is high.
// While a result waits under output stall, an empty input register still takes one word,
// and input stall is high whenever that register holds a word behind the waiting result.
// Size lines of more than LINE_LIMIT-2 bytes before the LF and sizes beyond SIZE_BITS bits
// end the stream with a bad size line event; any event other than data ends all output
// until reset.
module http_chunked_body_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  hcbd_pkg::in_word_t  item,
	output logic                res_valid,
	input  logic                res_stall,
	output hcbd_pkg::out_word_t res
);
	import hcbd_pkg::*;

	`include "assert_macros.svh"

	logic      valid_s1;
	in_word_t  word_s1;
	logic      advance;
	logic      core_valid;
	out_word_t core_res;
	logic      res_valid_q;
	out_word_t res_q;

	assign advance    = valid_s1 && !(res_valid_q && res_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			word_s1 <= item;
		end
	end

	hcbd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.word      (word_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && core_valid) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`HCBD_ASSERT_IMP(a_stall_needs_word, clk, arst_n, item_stall, valid_s1)
	`HCBD_ASSERT_NXT(a_quiet_after_end, clk, arst_n, res_valid && !res_stall && res.event_res != EV_DATA, !res_valid)
	`HCBD_ASSERT_IMP(a_last_only_data, clk, arst_n, res_valid && res.last_of_chunk, res.event_res == EV_DATA)

endmodule
